// ===== design/timed_message_scheduler_defines.svh =====
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; files that assert include it and supply i_clk and i_rst_n.
`ifndef TIMED_MESSAGE_SCHEDULER_DEFINES_SVH
`define TIMED_MESSAGE_SCHEDULER_DEFINES_SVH
`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define TMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Condition that must never hold outside reset.
`define TMS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define TMS_ASSERT(lbl, prop, msg)
`define TMS_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/tms_pkg.sv =====
// Shared types, codes and helpers of the timed message scheduler.
// Used by timed_message_scheduler; depends on nothing.
package tms_pkg;

    localparam int STORE_SLOTS_DEF = 32;
    localparam int FIFO_SLOTS_DEF  = 16;
    localparam int MSG_BYTES       = 3;

    localparam int DUE_W   = 63;
    localparam int BYTES_W = 24;
    localparam int SIZE_W  = 2;
    localparam int CNT_W   = 32;

    // item kinds
    localparam logic [2:0] MODE_SCHED = 3'd0;
    localparam logic [2:0] MODE_IMM   = 3'd1;
    localparam logic [2:0] MODE_TICK  = 3'd2;
    localparam logic [2:0] MODE_FLUSH = 3'd3;
    localparam logic [2:0] MODE_PANIC = 3'd4;
    localparam logic [2:0] MODE_CLEAR = 3'd5;

    // configuration register indexes
    localparam logic REG_TS_MODE  = 1'b0;
    localparam logic REG_LATE_THR = 1'b1;

    localparam logic [31:0] LATE_THR_RST = 32'd1000000;

    // panic messages: control change status, sustain off and all notes off
    localparam logic [7:0] STATUS_CC  = 8'hB0;
    localparam logic [7:0] CC_SUSTAIN = 8'd64;
    localparam logic [7:0] CC_ALL_OFF = 8'd123;
    localparam int         CHANNELS   = 16;

    typedef struct packed {
        logic               has;
        logic [BYTES_W-1:0] bytes;
        logic [SIZE_W-1:0]  size;
        logic [DUE_W-1:0]   stamp;
        logic               acc;
        logic [CNT_W-1:0]   sent;
        logic [CNT_W-1:0]   dropped;
        logic [CNT_W-1:0]   late;
        logic [DUE_W-1:0]   maxlat;
    } t_result;

    function automatic logic [BYTES_W-1:0] mask_bytes(logic [BYTES_W-1:0] b,
                                                      logic [SIZE_W-1:0] s);
        logic [BYTES_W-1:0] r;
        case (s)
            2'd0:    r = '0;
            2'd1:    r = {16'b0, b[7:0]};
            2'd2:    r = {8'b0, b[15:0]};
            default: r = b;
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

endpackage

// ===== design/timed_message_scheduler.sv =====
// Top level of the timed message scheduler: sequencer, store, FIFO, statistics.
// Depends on tms_pkg, tms_ram and timed_message_scheduler_defines.svh.
//
//  channel  direction  handshake                       payload
//  s_axis   in         s_axis_tvalid / s_axis_tready   tdata 168 bits, tuser = mode
//  m_axis   out        m_axis_tvalid / m_axis_tready   tdata 256 bits, tuser, tlast
//  cfg      in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// One item at a time; the input is ready only while the sequencer is idle.
// Each RAM has one read port and one write port. A schedule shifts every stored entry
// that is due later than the new one up one slot; into a full store, the later of the new
// item and the last entry (the new item on a tie) is dropped. Tick: sends each immediate
// message, then each stored message that is due, then closes. Panic: walks every channel
// and inserts two messages per selected channel.
// Results pass through a pending register and an output register: a stalled m_axis
// holds a send only when both are full, and holds the close-out while the output
// register is full. Reset is synchronous and clears control and statistics; RAM
// contents stay undefined and are never read unwritten.
`include "timed_message_scheduler_defines.svh"

module timed_message_scheduler #(
    parameter int STORE_SLOTS = tms_pkg::STORE_SLOTS_DEF,
    parameter int FIFO_SLOTS  = tms_pkg::FIFO_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // due_time[62:0], now_time[125:63], msg_bytes[149:126], msg_size[151:150],
    // channel_mask[167:152]
    input  logic [167:0] s_axis_tdata,
    // mode[2:0]
    input  logic [2:0]   s_axis_tuser,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // out_bytes[23:0], out_size[25:24], out_stamp[88:26], accepted[89],
    // sent_count[121:90], dropped_count[153:122], late_count[185:154],
    // max_lateness[248:186], zero[255:249]
    output logic [255:0] m_axis_tdata,
    // has_message[0]
    output logic [0:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    localparam int IDXW = $clog2(STORE_SLOTS);
    localparam int CNTW = $clog2(STORE_SLOTS + 1);
    localparam int HW   = IDXW + 2;
    localparam int FPW  = $clog2(FIFO_SLOTS);
    localparam int SW   = tms_pkg::DUE_W + tms_pkg::BYTES_W + tms_pkg::SIZE_W;
    localparam int FW   = tms_pkg::BYTES_W + tms_pkg::SIZE_W;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_CHK, S_INS_FULL, S_INS_STEP, S_INS_CMP, S_PANIC,
        S_FIFO_RD, S_FIFO_EMIT, S_ST_RD, S_ST_CHK, S_ST_EMIT, S_ST_DONE, S_FINISH
    } t_state;

    t_state r_state, n_state;

    // item registers
    logic [2:0]  r_mode, n_mode;
    logic [62:0] r_due, n_due;
    logic [62:0] r_now, n_now;
    logic [23:0] r_bytes, n_bytes;
    logic [1:0]  r_size, n_size;
    logic [15:0] r_mask, n_mask;
    logic        r_acc, n_acc;
    logic        r_lossless, n_lossless;
    logic [4:0]  r_ch, n_ch;
    logic        r_sub, n_sub;
    logic [62:0] r_lat, n_lat;

    // store and FIFO control
    logic [IDXW-1:0] r_head, n_head;
    logic [CNTW-1:0] r_fill, n_fill;
    logic [IDXW-1:0] r_pos, n_pos;
    logic [CNTW-1:0] r_idx, n_idx;
    logic [FPW-1:0]  r_rptr, n_rptr;
    logic [FPW-1:0]  r_wptr, n_wptr;

    // statistics and configuration
    logic [31:0] r_sent, n_sent;
    logic [31:0] r_dropped, n_dropped;
    logic [31:0] r_late, n_late;
    logic [62:0] r_worst, n_worst;
    logic        r_ts_mode;
    logic [31:0] r_late_thr;

    // result path
    tms_pkg::t_result r_pend, n_pend, r_out, n_out, new_res;
    logic             r_pend_v, n_pend_v, r_out_v, n_out_v, r_out_last, n_out_last;

    // RAM ports
    logic            st_we, st_re, ff_we, ff_re;
    logic [IDXW-1:0] st_rlog, st_wlog, st_raddr, st_waddr;
    logic [SW-1:0]   st_wdata, st_rdata;
    logic [FW-1:0]   ff_wdata, ff_rdata;
    logic [IDXW:0]   st_rsum, st_wsum;
    logic [HW-1:0]   head_sum;

    logic [62:0] rd_due;
    logic [23:0] rd_bytes;
    logic [1:0]  rd_size;

    logic        in_fire, out_free, can_push, size_ok, ff_full;
    logic [2:0]  in_mode;
    logic [1:0]  in_size;
    logic [23:0] in_bytes;
    logic [FPW-1:0] wptr_inc, rptr_inc;

    assign rd_due   = st_rdata[62:0];
    assign rd_bytes = st_rdata[86:63];
    assign rd_size  = st_rdata[88:87];

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign in_mode  = s_axis_tuser;
    assign in_size  = s_axis_tdata[151:150];
    assign in_bytes = tms_pkg::mask_bytes(s_axis_tdata[149:126], in_size);
    assign size_ok  = (in_size != 2'd0) && (in_size <= 2'(tms_pkg::MSG_BYTES));
    assign wptr_inc = (r_wptr == FPW'(FIFO_SLOTS - 1)) ? '0 : r_wptr + 1'b1;
    assign rptr_inc = (r_rptr == FPW'(FIFO_SLOTS - 1)) ? '0 : r_rptr + 1'b1;
    assign ff_full  = (wptr_inc == r_rptr);

    assign out_free = !r_out_v || m_axis_tready;
    assign can_push = !r_pend_v || out_free;

    // logical store slot to physical RAM address: wrap around the head
    assign st_rsum  = {1'b0, r_head} + {1'b0, st_rlog};
    assign st_wsum  = {1'b0, r_head} + {1'b0, st_wlog};
    assign st_raddr = (st_rsum >= (IDXW+1)'(STORE_SLOTS))
                      ? IDXW'(st_rsum - (IDXW+1)'(STORE_SLOTS)) : IDXW'(st_rsum);
    assign st_waddr = (st_wsum >= (IDXW+1)'(STORE_SLOTS))
                      ? IDXW'(st_wsum - (IDXW+1)'(STORE_SLOTS)) : IDXW'(st_wsum);
    assign head_sum = HW'(r_head) + HW'(r_idx);

    assign ff_wdata = {in_size, in_bytes};
    assign ff_we    = in_fire && (in_mode == tms_pkg::MODE_IMM) && size_ok && !ff_full;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_due      = r_due;
        n_now      = r_now;
        n_bytes    = r_bytes;
        n_size     = r_size;
        n_mask     = r_mask;
        n_acc      = r_acc;
        n_lossless = r_lossless;
        n_ch       = r_ch;
        n_sub      = r_sub;
        n_lat      = r_lat;
        n_head     = r_head;
        n_fill     = r_fill;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_rptr     = r_rptr;
        n_wptr     = r_wptr;
        n_sent     = r_sent;
        n_dropped  = r_dropped;
        n_late     = r_late;
        n_worst    = r_worst;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_out      = r_out;
        n_out_v    = r_out_v && !m_axis_tready;
        n_out_last = r_out_last;
        st_we      = 1'b0;
        st_re      = 1'b0;
        st_rlog    = '0;
        st_wlog    = r_pos;
        st_wdata   = {r_size, r_bytes, r_due};
        ff_re      = 1'b0;
        new_res    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_mode     = in_mode;
                    n_due      = s_axis_tdata[62:0];
                    n_now      = s_axis_tdata[125:63];
                    n_bytes    = in_bytes;
                    n_size     = in_size;
                    n_mask     = s_axis_tdata[167:152];
                    n_acc      = 1'b0;
                    n_lossless = 1'b1;
                    n_ch       = '0;
                    n_sub      = 1'b0;
                    n_idx      = '0;
                    n_state    = S_FINISH;
                    case (in_mode)
                        tms_pkg::MODE_SCHED: begin
                            if (!size_ok) begin
                                n_dropped = tms_pkg::sat_inc(r_dropped);
                            end else begin
                                n_state = S_INS_CHK;
                            end
                        end
                        tms_pkg::MODE_IMM: begin
                            if (!size_ok || ff_full) begin
                                n_dropped = tms_pkg::sat_inc(r_dropped);
                            end else begin
                                n_wptr = wptr_inc;
                                n_acc  = 1'b1;
                            end
                        end
                        tms_pkg::MODE_TICK:  n_state = S_FIFO_RD;
                        tms_pkg::MODE_FLUSH: n_fill = '0;
                        tms_pkg::MODE_PANIC: begin
                            n_fill  = '0;
                            n_state = S_PANIC;
                        end
                        tms_pkg::MODE_CLEAR: begin
                            n_sent    = '0;
                            n_dropped = '0;
                            n_late    = '0;
                            n_worst   = '0;
                        end
                        default: ;
                    endcase
                end
            end

            // sorted insert of r_due/r_bytes/r_size, shifting later entries up
            S_INS_CHK: begin
                n_lossless = 1'b1;
                if (r_fill == CNTW'(STORE_SLOTS)) begin
                    st_re   = 1'b1;
                    st_rlog = IDXW'(STORE_SLOTS - 1);
                    n_state = S_INS_FULL;
                end else begin
                    n_pos   = IDXW'(r_fill);
                    n_state = S_INS_STEP;
                end
            end
            S_INS_FULL: begin
                n_dropped = tms_pkg::sat_inc(r_dropped);
                if (r_due >= rd_due) begin
                    n_state = (r_mode == tms_pkg::MODE_PANIC) ? S_PANIC : S_FINISH;
                end else begin
                    n_fill     = CNTW'(STORE_SLOTS - 1);
                    n_lossless = 1'b0;
                    n_pos      = IDXW'(STORE_SLOTS - 1);
                    n_state    = S_INS_STEP;
                end
            end
            S_INS_STEP: begin
                if (r_pos == '0) begin
                    st_we   = 1'b1;
                    n_fill  = r_fill + 1'b1;
                    n_acc   = (r_mode == tms_pkg::MODE_SCHED) ? r_lossless : r_acc;
                    n_state = (r_mode == tms_pkg::MODE_PANIC) ? S_PANIC : S_FINISH;
                end else begin
                    st_re   = 1'b1;
                    st_rlog = r_pos - 1'b1;
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                st_we = 1'b1;
                if (rd_due > r_due) begin
                    st_wdata = st_rdata;
                    n_pos    = r_pos - 1'b1;
                    n_state  = S_INS_STEP;
                end else begin
                    n_fill  = r_fill + 1'b1;
                    n_acc   = (r_mode == tms_pkg::MODE_SCHED) ? r_lossless : r_acc;
                    n_state = (r_mode == tms_pkg::MODE_PANIC) ? S_PANIC : S_FINISH;
                end
            end

            // walk the channel mask, two off messages per selected channel
            S_PANIC: begin
                if (r_ch == 5'(tms_pkg::CHANNELS)) begin
                    n_state = S_FINISH;
                end else if (!r_mask[r_ch[3:0]]) begin
                    n_ch = r_ch + 1'b1;
                end else begin
                    n_due   = '0;
                    n_size  = 2'd3;
                    n_bytes = {8'b0, r_sub ? tms_pkg::CC_ALL_OFF : tms_pkg::CC_SUSTAIN,
                               tms_pkg::STATUS_CC | {4'b0, r_ch[3:0]}};
                    n_sub   = !r_sub;
                    n_ch    = r_sub ? r_ch + 1'b1 : r_ch;
                    n_state = S_INS_CHK;
                end
            end

            // tick: drain the FIFO first
            S_FIFO_RD: begin
                if (r_rptr == r_wptr) begin
                    n_state = S_ST_RD;
                end else begin
                    ff_re   = 1'b1;
                    n_state = S_FIFO_EMIT;
                end
            end
            S_FIFO_EMIT: begin
                if (can_push) begin
                    n_sent          = tms_pkg::sat_inc(r_sent);
                    new_res.has     = 1'b1;
                    new_res.bytes   = ff_rdata[23:0];
                    new_res.size    = ff_rdata[25:24];
                    new_res.sent    = n_sent;
                    new_res.dropped = r_dropped;
                    new_res.late    = r_late;
                    new_res.maxlat  = r_worst;
                    if (r_pend_v) begin
                        n_out      = r_pend;
                        n_out_last = 1'b0;
                        n_out_v    = 1'b1;
                    end
                    n_pend   = new_res;
                    n_pend_v = 1'b1;
                    n_rptr   = rptr_inc;
                    n_state  = S_FIFO_RD;
                end
            end

            // then every due entry (every entry in timestamp mode) from the head of the store
            S_ST_RD: begin
                if (r_idx == r_fill) begin
                    n_state = S_ST_DONE;
                end else begin
                    st_re   = 1'b1;
                    st_rlog = IDXW'(r_idx);
                    n_state = S_ST_CHK;
                end
            end
            S_ST_CHK: begin
                if (!r_ts_mode && (rd_due > r_now)) begin
                    n_state = S_ST_DONE;
                end else begin
                    n_lat   = r_now - rd_due;
                    n_state = S_ST_EMIT;
                end
            end
            S_ST_EMIT: begin
                if (can_push) begin
                    n_sent = tms_pkg::sat_inc(r_sent);
                    if (!r_ts_mode && (rd_due != '0)) begin
                        if (r_lat > {31'b0, r_late_thr}) begin
                            n_late = tms_pkg::sat_inc(r_late);
                        end
                        if (r_lat > r_worst) begin
                            n_worst = r_lat;
                        end
                    end
                    new_res.has     = 1'b1;
                    new_res.bytes   = rd_bytes;
                    new_res.size    = rd_size;
                    new_res.stamp   = r_ts_mode ? rd_due : '0;
                    new_res.sent    = n_sent;
                    new_res.dropped = r_dropped;
                    new_res.late    = n_late;
                    new_res.maxlat  = n_worst;
                    if (r_pend_v) begin
                        n_out      = r_pend;
                        n_out_last = 1'b0;
                        n_out_v    = 1'b1;
                    end
                    n_pend   = new_res;
                    n_pend_v = 1'b1;
                    n_idx    = r_idx + 1'b1;
                    n_state  = S_ST_RD;
                end
            end
            S_ST_DONE: begin
                // advance the head past the sent entries
                n_head  = (head_sum >= HW'(STORE_SLOTS))
                          ? IDXW'(head_sum - HW'(STORE_SLOTS)) : IDXW'(head_sum);
                n_fill  = r_fill - r_idx;
                n_state = S_FINISH;
            end

            // hand the final result to the output register, marked last
            S_FINISH: begin
                if (out_free) begin
                    if (r_pend_v) begin
                        n_out = r_pend;
                    end else begin
                        n_out         = '0;
                        n_out.acc     = r_acc;
                        n_out.sent    = r_sent;
                        n_out.dropped = r_dropped;
                        n_out.late    = r_late;
                        n_out.maxlat  = r_worst;
                    end
                    n_out_last = 1'b1;
                    n_out_v    = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_fill     <= '0;
            r_rptr     <= '0;
            r_wptr     <= '0;
            r_sent     <= '0;
            r_dropped  <= '0;
            r_late     <= '0;
            r_worst    <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_ts_mode  <= 1'b0;
            r_late_thr <= tms_pkg::LATE_THR_RST;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_rptr    <= n_rptr;
            r_wptr    <= n_wptr;
            r_sent    <= n_sent;
            r_dropped <= n_dropped;
            r_late    <= n_late;
            r_worst   <= n_worst;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tms_pkg::REG_TS_MODE:  r_ts_mode  <= i_cfg_data[0];
                    tms_pkg::REG_LATE_THR: r_late_thr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_mode     <= n_mode;
        r_due      <= n_due;
        r_now      <= n_now;
        r_bytes    <= n_bytes;
        r_size     <= n_size;
        r_mask     <= n_mask;
        r_acc      <= n_acc;
        r_lossless <= n_lossless;
        r_ch       <= n_ch;
        r_sub      <= n_sub;
        r_lat      <= n_lat;
        r_pos      <= n_pos;
        r_idx      <= n_idx;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    tms_ram #(.WIDTH(SW), .DEPTH(STORE_SLOTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_re   (st_re),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    tms_ram #(.WIDTH(FW), .DEPTH(FIFO_SLOTS)) u_fifo (
        .i_clk  (i_clk),
        .i_we   (ff_we),
        .i_waddr(r_wptr),
        .i_wdata(ff_wdata),
        .i_re   (ff_re),
        .i_raddr(r_rptr),
        .o_rdata(ff_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out.has;
    assign m_axis_tdata  = {7'b0, r_out.maxlat, r_out.late, r_out.dropped, r_out.sent,
                            r_out.acc, r_out.stamp, r_out.size, r_out.bytes};

    `TMS_NEVER(a_fill_bound, r_fill > CNTW'(STORE_SLOTS), "store fill above capacity")
    `TMS_NEVER(a_idle_no_pend, (r_state == S_IDLE) && r_pend_v, "pending result left at idle")
    `TMS_ASSERT(a_sent_mono, (r_state != S_IDLE) |=> (r_sent >= $past(r_sent)), "sent count fell")
    `TMS_NEVER(a_ptr_range, (r_rptr > FPW'(FIFO_SLOTS - 1)) || (r_wptr > FPW'(FIFO_SLOTS - 1)),
        "FIFO pointer out of range")
    `TMS_ASSERT(a_emit_read, (r_state == S_ST_EMIT) |-> (r_idx < r_fill), "send beyond fill")

endmodule

// ===== design/tms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced for the message store and the immediate FIFO.
module tms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
